// ===== design/dlsq_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsq_pkg
// Shared constants, codes and types of the delta-list sleep queue.
// ----------------------------------------------------------------------------
package dlsq_pkg;

   localparam int NUM_SLOTS_DEF  = 16;
   localparam int DELAY_BITS_DEF = 16;

   localparam int ID_W     = 4;
   localparam int DELAY_W  = 16;
   localparam int PRIO_W   = 8;

   typedef enum logic {
      OP_SLEEP = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      WAKE_NONE   = 2'd0,
      WAKE_HIGHER = 2'd1,
      WAKE_EQUAL  = 2'd2,
      WAKE_LOWER  = 2'd3
   } wake_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_TICK_EVAL,
      ST_INS_WALK,
      ST_INS_PRED,
      ST_INS_CUR,
      ST_INS_NEW,
      ST_DONE
   } state_type;

endpackage

// ===== design/dlsq_if.sv =====
// ----------------------------------------------------------------------------
// dlsq_if
// Request and response channels of the sleep queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlsq_req_if;
   logic                         valid;
   logic                         ready;
   dlsq_pkg::op_type             op;
   logic [dlsq_pkg::ID_W-1:0]    proc_id;
   logic [dlsq_pkg::DELAY_W-1:0] delay;
   logic [dlsq_pkg::PRIO_W-1:0]  new_prio;
   logic [dlsq_pkg::PRIO_W-1:0]  active_prio;

   modport source (output valid, op, proc_id, delay, new_prio, active_prio, input ready);
   modport sink   (input valid, op, proc_id, delay, new_prio, active_prio, output ready);
endinterface

interface dlsq_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      woke;
   logic [dlsq_pkg::ID_W-1:0] woken_id;
   dlsq_pkg::wake_type        wake_action;
   logic                      ignored;

   modport source (output valid, woke, woken_id, wake_action, ignored, input ready);
   modport sink   (input valid, woke, woken_id, wake_action, ignored, output ready);
endinterface

// ===== design/dlsq_mem.sv =====
// ----------------------------------------------------------------------------
// dlsq_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dlsq_mem #(
   parameter int DEPTH  = dlsq_pkg::NUM_SLOTS_DEF,
   parameter int ADDR_W = $clog2(dlsq_pkg::NUM_SLOTS_DEF),
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] ram_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dlsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlsq_ctrl
// Sequencer of the sleep queue: list walk, link-in, tick and wake, result
// register.
// ----------------------------------------------------------------------------
module dlsq_ctrl #(
   parameter int NUM_SLOTS  = dlsq_pkg::NUM_SLOTS_DEF,
   parameter int DELAY_BITS = dlsq_pkg::DELAY_BITS_DEF,
   parameter int SLOT_W     = $clog2(NUM_SLOTS),
   parameter int LINK_W     = $clog2(NUM_SLOTS + 1),
   parameter int DATA_W     = LINK_W + DELAY_BITS + 1 + dlsq_pkg::PRIO_W
) (
   input  logic              clock,
   input  logic              reset,
   dlsq_req_if.sink          req_if,
   dlsq_rsp_if.source        rsp_if,
   output logic              mem_wr_en,
   output logic [SLOT_W-1:0] mem_wr_addr,
   output logic [DATA_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [SLOT_W-1:0] mem_rd_addr,
   input  logic [DATA_W-1:0] mem_rd_data
);

   localparam int DELTA_W = DELAY_BITS + 1;
   localparam int PRIO_W  = dlsq_pkg::PRIO_W;
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_SLOTS);

   dlsq_pkg::state_type          state_ff, state_in;
   dlsq_pkg::op_type             op_ff, op_in;
   logic [dlsq_pkg::ID_W-1:0]    pid_ff, pid_in;
   logic signed [DELTA_W-1:0]    rem_ff, rem_in;
   logic [PRIO_W-1:0]            new_prio_ff, new_prio_in;
   logic [PRIO_W-1:0]            active_ff, active_in;
   logic [LINK_W-1:0]            cur_ff, cur_in;
   logic [LINK_W-1:0]            pred_ff, pred_in;
   logic [DATA_W-1:0]            pred_ent_ff, pred_ent_in;
   logic [DATA_W-1:0]            cur_ent_ff, cur_ent_in;
   logic [SLOT_W-1:0]            head_ff, head_in;
   logic                         nonempty_ff, nonempty_in;
   logic [NUM_SLOTS-1:0]         queued_ff, queued_in;
   logic                         res_woke_ff, res_woke_in;
   logic [dlsq_pkg::ID_W-1:0]    res_id_ff, res_id_in;
   dlsq_pkg::wake_type           res_action_ff, res_action_in;
   logic                         res_ignored_ff, res_ignored_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_woke_ff, rsp_woke_in;
   logic [dlsq_pkg::ID_W-1:0]    rsp_id_ff, rsp_id_in;
   dlsq_pkg::wake_type           rsp_action_ff, rsp_action_in;
   logic                         rsp_ignored_ff, rsp_ignored_in;

   logic [47:0]                  delay_ext;
   logic [7:0]                   pid_ext;
   logic [7:0]                   head_ext;
   logic [SLOT_W-1:0]            slot;
   logic                         slot_ok;
   logic [LINK_W-1:0]            rd_link;
   logic signed [DELTA_W-1:0]    rd_delta;
   logic [PRIO_W-1:0]            rd_prio;
   logic signed [DELTA_W-1:0]    tick_delta;
   logic signed [DELTA_W-1:0]    cur_delta;

   assign delay_ext  = {32'd0, req_if.delay};
   assign pid_ext    = {4'd0, pid_ff};
   assign head_ext   = 8'(head_ff);
   assign slot       = pid_ext[SLOT_W-1:0];
   assign slot_ok    = 32'(pid_ff) < 32'(NUM_SLOTS);
   assign rd_link    = mem_rd_data[DATA_W-1 -: LINK_W];
   assign rd_delta   = $signed(mem_rd_data[PRIO_W +: DELTA_W]);
   assign rd_prio    = mem_rd_data[PRIO_W-1:0];
   assign tick_delta = rd_delta - DELTA_W'(1);
   assign cur_delta  = $signed(cur_ent_ff[PRIO_W +: DELTA_W]) - rem_ff;

   assign req_if.ready       = (state_ff == dlsq_pkg::ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.woke        = rsp_woke_ff;
   assign rsp_if.woken_id    = rsp_id_ff;
   assign rsp_if.wake_action = rsp_action_ff;
   assign rsp_if.ignored     = rsp_ignored_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      pid_in         = pid_ff;
      rem_in         = rem_ff;
      new_prio_in    = new_prio_ff;
      active_in      = active_ff;
      cur_in         = cur_ff;
      pred_in        = pred_ff;
      pred_ent_in    = pred_ent_ff;
      cur_ent_in     = cur_ent_ff;
      head_in        = head_ff;
      nonempty_in    = nonempty_ff;
      queued_in      = queued_ff;
      res_woke_in    = res_woke_ff;
      res_id_in      = res_id_ff;
      res_action_in  = res_action_ff;
      res_ignored_in = res_ignored_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_woke_in    = rsp_woke_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_ignored_in = rsp_ignored_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = slot;
      mem_wr_data    = {cur_ff, rem_ff, new_prio_ff};
      mem_rd_en      = 1'b0;
      mem_rd_addr    = head_ff;

      unique case (state_ff)
         dlsq_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               op_in       = req_if.op;
               pid_in      = req_if.proc_id;
               rem_in      = $signed({1'b0, delay_ext[DELAY_BITS-1:0]});
               new_prio_in = req_if.new_prio;
               active_in   = req_if.active_prio;
               state_in    = dlsq_pkg::ST_START;
            end
         end

         dlsq_pkg::ST_START: begin
            res_woke_in    = 1'b0;
            res_id_in      = '0;
            res_action_in  = dlsq_pkg::WAKE_NONE;
            res_ignored_in = 1'b0;
            if (op_ff == dlsq_pkg::OP_TICK) begin
               if (nonempty_ff) begin
                  mem_rd_en = 1'b1;
                  state_in  = dlsq_pkg::ST_TICK_EVAL;
               end else begin
                  state_in  = dlsq_pkg::ST_DONE;
               end
            end else if (rem_ff == '0 || !slot_ok || queued_ff[slot]) begin
               res_ignored_in = 1'b1;
               state_in       = dlsq_pkg::ST_DONE;
            end else if (!nonempty_ff) begin
               mem_wr_en       = 1'b1;
               mem_wr_data     = {NIL_LINK, rem_ff, new_prio_ff};
               head_in         = slot;
               nonempty_in     = 1'b1;
               queued_in[slot] = 1'b1;
               state_in        = dlsq_pkg::ST_DONE;
            end else begin
               cur_in    = LINK_W'(head_ff);
               pred_in   = NIL_LINK;
               mem_rd_en = 1'b1;
               state_in  = dlsq_pkg::ST_INS_WALK;
            end
         end

         dlsq_pkg::ST_TICK_EVAL: begin
            if (tick_delta[DELTA_W-1] || tick_delta == '0) begin
               if (rd_link == NIL_LINK) begin
                  head_in     = '0;
                  nonempty_in = 1'b0;
               end else begin
                  head_in     = rd_link[SLOT_W-1:0];
               end
               queued_in[head_ff] = 1'b0;
               res_woke_in        = 1'b1;
               res_id_in          = head_ext[dlsq_pkg::ID_W-1:0];
               if (rd_prio > active_ff) begin
                  res_action_in = dlsq_pkg::WAKE_HIGHER;
               end else if (rd_prio == active_ff) begin
                  res_action_in = dlsq_pkg::WAKE_EQUAL;
               end else begin
                  res_action_in = dlsq_pkg::WAKE_LOWER;
               end
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = head_ff;
               mem_wr_data = {rd_link, tick_delta, rd_prio};
            end
            state_in = dlsq_pkg::ST_DONE;
         end

         dlsq_pkg::ST_INS_WALK: begin
            if (rem_ff > rd_delta) begin
               rem_in      = rem_ff - rd_delta;
               pred_in     = cur_ff;
               pred_ent_in = mem_rd_data;
               cur_in      = rd_link;
               if (rd_link == NIL_LINK) begin
                  state_in    = dlsq_pkg::ST_INS_PRED;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = rd_link[SLOT_W-1:0];
               end
            end else begin
               cur_ent_in = mem_rd_data;
               state_in   = dlsq_pkg::ST_INS_PRED;
            end
         end

         dlsq_pkg::ST_INS_PRED: begin
            if (pred_ff == NIL_LINK) begin
               head_in     = slot;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pred_ff[SLOT_W-1:0];
               mem_wr_data = {LINK_W'(slot), pred_ent_ff[DELTA_W+PRIO_W-1:0]};
            end
            state_in = dlsq_pkg::ST_INS_CUR;
         end

         dlsq_pkg::ST_INS_CUR: begin
            if (cur_ff != NIL_LINK) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cur_ff[SLOT_W-1:0];
               mem_wr_data = {cur_ent_ff[DATA_W-1 -: LINK_W], cur_delta,
                              cur_ent_ff[PRIO_W-1:0]};
            end
            state_in = dlsq_pkg::ST_INS_NEW;
         end

         dlsq_pkg::ST_INS_NEW: begin
            mem_wr_en       = 1'b1;
            queued_in[slot] = 1'b1;
            state_in        = dlsq_pkg::ST_DONE;
         end

         dlsq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_woke_in    = res_woke_ff;
               rsp_id_in      = res_id_ff;
               rsp_action_in  = res_action_ff;
               rsp_ignored_in = res_ignored_ff;
               state_in       = dlsq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dlsq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlsq_pkg::ST_IDLE;
         head_ff      <= '0;
         nonempty_ff  <= 1'b0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         nonempty_ff  <= nonempty_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pid_ff         <= pid_in;
      rem_ff         <= rem_in;
      new_prio_ff    <= new_prio_in;
      active_ff      <= active_in;
      cur_ff         <= cur_in;
      pred_ff        <= pred_in;
      pred_ent_ff    <= pred_ent_in;
      cur_ent_ff     <= cur_ent_in;
      res_woke_ff    <= res_woke_in;
      res_id_ff      <= res_id_in;
      res_action_ff  <= res_action_in;
      res_ignored_ff <= res_ignored_in;
      rsp_woke_ff    <= rsp_woke_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_ignored_ff <= rsp_ignored_in;
   end

endmodule

// ===== design/delta_list_sleep_queue.sv =====
// ----------------------------------------------------------------------------
// delta_list_sleep_queue
// Sleep queue kept as a delta list over a table of process slots.
// ----------------------------------------------------------------------------
// Channels: req_if carries sleep requests (op sleep: proc_id, delay, new_prio)
// and timer ticks (op tick: active_prio); rsp_if returns exactly one result
// per request: woke, woken_id and wake_action for ticks, ignored for sleeps.
// Steps per item: a tick on a non-empty queue reads the head entry from the
// slot table, then wakes it or writes it back with its delta lowered; a tick
// on an empty queue, a rejected sleep and a sleep into an empty queue go
// straight to the result; a sleep into a non-empty queue walks the list, one
// slot table read per entry visited, then updates the predecessor link, the
// next entry's delta and the new entry. One item is in work at a time;
// req_if.ready rises again as its result is loaded.
// Reset empties the queue at once; the slot table is not cleared and needs
// no clearing pass. A stalled receiver holds the result in the output
// register while the next item is taken and worked on; that item waits for
// the register to empty before its result is loaded.
// ----------------------------------------------------------------------------
module delta_list_sleep_queue #(
   parameter int NUM_SLOTS  = dlsq_pkg::NUM_SLOTS_DEF,
   parameter int DELAY_BITS = dlsq_pkg::DELAY_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dlsq_req_if.sink   req_if,
   dlsq_rsp_if.source rsp_if
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LINK_W = $clog2(NUM_SLOTS + 1);
   localparam int DATA_W = LINK_W + DELAY_BITS + 1 + dlsq_pkg::PRIO_W;

   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [SLOT_W-1:0] mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   dlsq_ctrl #(
      .NUM_SLOTS  (NUM_SLOTS),
      .DELAY_BITS (DELAY_BITS),
      .SLOT_W     (SLOT_W),
      .LINK_W     (LINK_W),
      .DATA_W     (DATA_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   dlsq_mem #(
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (SLOT_W),
      .DATA_W (DATA_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delta-list sleep queue. Sleep requests and
// timer ticks are sent over the request channel in random bursts, while the
// response channel stalls on its own pattern. A software copy of the delta
// list predicts every response. Each response is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_SLOTS    = dlsq_pkg::NUM_SLOTS_DEF;
   localparam int NIL_SLOT     = NUM_SLOTS;
   localparam int RANDOM_ITEMS = 1300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      dlsq_pkg::op_type                  op;
      logic [dlsq_pkg::ID_W-1:0]         proc_id;
      logic [dlsq_pkg::DELAY_W-1:0]      delay;
      logic [dlsq_pkg::PRIO_W-1:0]       new_prio;
      logic [dlsq_pkg::PRIO_W-1:0]       active_prio;
   } sleep_request_type;

   typedef struct packed {
      logic                              woke;
      logic [dlsq_pkg::ID_W-1:0]         woken_id;
      dlsq_pkg::wake_type                wake_action;
      logic                              ignored;
   } wake_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlsq_req_if req_if ();
   dlsq_rsp_if rsp_if ();

   delta_list_sleep_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the delta list
   int unsigned     list_head;
   bit              list_busy;
   int unsigned     next_slot  [NUM_SLOTS];
   longint          wait_delta [NUM_SLOTS];
   logic [dlsq_pkg::PRIO_W-1:0] wait_prio [NUM_SLOTS];

   wake_report_type wake_reports_due[$];
   int unsigned     mismatch_count = 0;
   int unsigned     quiet_cycles   = 0;
   int unsigned     burst_left     = 0;
   logic [15:0]     ready_pattern  = 16'hffff;
   int unsigned     ready_step     = 0;

   function automatic bit slot_is_sleeping(input int unsigned slot);
      int unsigned cur;
      if (!list_busy) return 1'b0;
      cur = list_head;
      for (int steps = 0; steps < NUM_SLOTS && cur < NUM_SLOTS; steps++) begin
         if (cur == slot) return 1'b1;
         cur = next_slot[cur];
      end
      return 1'b0;
   endfunction

   function automatic wake_report_type advance_sleep_queue(input sleep_request_type item);
      wake_report_type report;
      int unsigned     cur;
      int unsigned     pred;
      int unsigned     slot;
      longint          remain;
      report.woke        = 1'b0;
      report.woken_id    = '0;
      report.wake_action = dlsq_pkg::WAKE_NONE;
      report.ignored     = 1'b0;
      slot = 32'(item.proc_id);
      if (item.op == dlsq_pkg::OP_SLEEP) begin
         remain = 64'(item.delay);
         if (remain <= 0 || slot >= NUM_SLOTS || slot_is_sleeping(slot)) begin
            report.ignored = 1'b1;
            return report;
         end
         wait_prio[slot] = item.new_prio;
         if (!list_busy) begin
            list_head        = slot;
            list_busy        = 1'b1;
            next_slot[slot]  = NIL_SLOT;
            wait_delta[slot] = remain;
            return report;
         end
         cur  = list_head;
         pred = NIL_SLOT;
         for (int steps = 0; steps < NUM_SLOTS && cur < NUM_SLOTS
              && remain > wait_delta[cur]; steps++) begin
            remain -= wait_delta[cur];
            pred    = cur;
            cur     = next_slot[cur];
         end
         if (cur >= NUM_SLOTS) cur = NIL_SLOT;
         if (pred == NIL_SLOT) list_head = slot;
         else next_slot[pred] = slot;
         next_slot[slot] = cur;
         if (cur < NUM_SLOTS) wait_delta[cur] -= remain;
         wait_delta[slot] = remain;
      end else if (list_busy) begin
         cur = list_head;
         wait_delta[cur] -= 1;
         if (wait_delta[cur] <= 0) begin
            if (next_slot[cur] < NUM_SLOTS) begin
               list_head = next_slot[cur];
            end else begin
               list_head = 0;
               list_busy = 1'b0;
            end
            report.woke     = 1'b1;
            report.woken_id = cur[dlsq_pkg::ID_W-1:0];
            if (wait_prio[cur] > item.active_prio)
               report.wake_action = dlsq_pkg::WAKE_HIGHER;
            else if (wait_prio[cur] == item.active_prio)
               report.wake_action = dlsq_pkg::WAKE_EQUAL;
            else
               report.wake_action = dlsq_pkg::WAKE_LOWER;
         end
      end
      return report;
   endfunction

   function automatic sleep_request_type sleep_req(input int unsigned slot,
                                                   input int unsigned ticks,
                                                   input int unsigned prio);
      sleep_request_type item;
      item.op          = dlsq_pkg::OP_SLEEP;
      item.proc_id     = dlsq_pkg::ID_W'(slot);
      item.delay       = dlsq_pkg::DELAY_W'(ticks);
      item.new_prio    = dlsq_pkg::PRIO_W'(prio);
      item.active_prio = dlsq_pkg::PRIO_W'($urandom);
      return item;
   endfunction

   function automatic sleep_request_type tick_req(input int unsigned active);
      sleep_request_type item;
      item.op          = dlsq_pkg::OP_TICK;
      item.proc_id     = dlsq_pkg::ID_W'($urandom);
      item.delay       = dlsq_pkg::DELAY_W'($urandom);
      item.new_prio    = dlsq_pkg::PRIO_W'($urandom);
      item.active_prio = dlsq_pkg::PRIO_W'(active);
      return item;
   endfunction

   // drive one request; called and returning at a falling edge
   task automatic send(input sleep_request_type item);
      wake_report_type report;
      int unsigned     gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.op          <= item.op;
      req_if.proc_id     <= item.proc_id;
      req_if.delay       <= item.delay;
      req_if.new_prio    <= item.new_prio;
      req_if.active_prio <= item.active_prio;
      req_if.valid       <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      report = advance_sleep_queue(item);
      wake_reports_due.push_back(report);
      @(negedge clock);
   endtask

   task automatic test_empty_tick();
      send(tick_req(255));
   endtask

   task automatic test_zero_delay();
      send(sleep_req(3, 0, 255));
   endtask

   task automatic test_wake_priority();
      send(sleep_req(0, 1, 255));
      send(tick_req(0));
      send(sleep_req(15, 1, 128));
      send(tick_req(128));
      send(sleep_req(5, 1, 0));
      send(tick_req(255));
   endtask

   // head, middle and tail insertion, a duplicate slot, and an equal
   // cumulative delay that leaves a zero delta behind
   task automatic test_list_order();
      send(sleep_req(1, 4, 10));
      send(sleep_req(1, 2, 20));
      send(sleep_req(2, 4, 30));
      send(sleep_req(3, 2, 40));
      send(sleep_req(4, 6, 50));
      send(sleep_req(6, 3, 60));
      repeat (7) send(tick_req($urandom_range(0, 255)));
   endtask

   task automatic test_long_delay();
      send(sleep_req(7, 65535, 255));
   endtask

   task automatic test_random_traffic();
      sleep_request_type item;
      int unsigned       pick;
      int unsigned       depth;
      int unsigned       cur;
      int unsigned       prio;
      longint            reach;
      int unsigned       free_slots[$];
      for (int sent = 0; sent < RANDOM_ITEMS; sent++) begin
         free_slots.delete();
         for (int s = 0; s < NUM_SLOTS; s++)
            if (!slot_is_sleeping(s)) free_slots.push_back(s);
         prio = ($urandom_range(0, 2) == 0) ? $urandom_range(120, 123) : $urandom_range(0, 255);
         if ($urandom_range(0, 1) == 0) begin
            item = tick_req(($urandom_range(0, 2) == 0) ? $urandom_range(120, 123)
                                                        : $urandom_range(0, 255));
         end else begin
            item = sleep_req($urandom_range(0, 15), $urandom_range(1, 24), prio);
            pick = $urandom_range(0, 99);
            if (pick >= 12 && free_slots.size() != 0)
               item.proc_id = dlsq_pkg::ID_W'(
                  free_slots[$urandom_range(0, free_slots.size() - 1)]);
            pick = $urandom_range(0, 99);
            if (pick < 15 && list_busy) begin
               // land exactly on an existing cumulative delay
               depth = $urandom_range(0, NUM_SLOTS - 1);
               reach = 0;
               cur   = list_head;
               for (int steps = 0; steps <= depth && cur < NUM_SLOTS; steps++) begin
                  reach += wait_delta[cur];
                  cur    = next_slot[cur];
               end
               if (reach > 0 && reach < 65536) item.delay = dlsq_pkg::DELAY_W'(reach);
            end else if (pick < 18) begin
               item.delay = dlsq_pkg::DELAY_W'($urandom_range(25, 300));
            end
            if ($urandom_range(0, 99) < 4) item.delay = '0;
         end
         send(item);
      end
   endtask

   always @(negedge clock) begin
      if (ready_step % 64 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern = 16'hffff;
            1: ready_pattern = 16'h0001 << $urandom_range(0, 15);
            default: ready_pattern = 16'($urandom) | 16'h0001;
         endcase
      end
      rsp_if.ready <= ready_pattern[ready_step[3:0]];
      ready_step++;
   end

   always @(posedge clock) begin
      wake_report_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (wake_reports_due.size() == 0) begin
            $display("%0t: unexpected transfer woke=%0d id=%0d action=%0d ignored=%0d",
                     $time, rsp_if.woke, rsp_if.woken_id, rsp_if.wake_action,
                     rsp_if.ignored);
            mismatch_count++;
         end else begin
            want = wake_reports_due.pop_front();
            if (rsp_if.woke !== want.woke) begin
               $display("%0t: woke expected %0d got %0d", $time, want.woke, rsp_if.woke);
               mismatch_count++;
            end
            if (rsp_if.woken_id !== want.woken_id) begin
               $display("%0t: woken_id expected %0d got %0d", $time, want.woken_id,
                        rsp_if.woken_id);
               mismatch_count++;
            end
            if (rsp_if.wake_action !== want.wake_action) begin
               $display("%0t: wake_action expected %0d got %0d", $time, want.wake_action,
                        rsp_if.wake_action);
               mismatch_count++;
            end
            if (rsp_if.ignored !== want.ignored) begin
               $display("%0t: ignored expected %0d got %0d", $time, want.ignored,
                        rsp_if.ignored);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.op          = dlsq_pkg::OP_SLEEP;
      req_if.proc_id     = '0;
      req_if.delay       = '0;
      req_if.new_prio    = '0;
      req_if.active_prio = '0;
      rsp_if.ready       = 1'b0;
      list_head = 0;
      list_busy = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         next_slot[s]  = NIL_SLOT;
         wait_delta[s] = 0;
         wait_prio[s]  = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_tick();
      test_zero_delay();
      test_wake_priority();
      test_list_order();
      test_long_delay();
      test_random_traffic();

      req_if.valid <= 1'b0;
      while (wake_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
